// ----- sv/cfpc_pkg.sv -----
// Package for the command-FIFO pointer controller: widths, register offsets,
// control bit positions and the sequencer state type. No dependencies.
`default_nettype none
package cfpc_pkg;
    localparam int ADDR_BITS   = 26;
    localparam int BURST_BYTES = 32;
    localparam logic [31:0] ADDR_MASK = 32'h03ff_ffe0;
    localparam logic [31:0] BURST32   = 32'd32;

    localparam logic [1:0] CMD_READ   = 2'd0;
    localparam logic [1:0] CMD_WRITE  = 2'd1;
    localparam logic [1:0] CMD_GATHER = 2'd2;
    localparam logic [1:0] CMD_STEP   = 2'd3;

    localparam int CTL_READ  = 0;
    localparam int CTL_BPINT = 1;
    localparam int CTL_OVF   = 2;
    localparam int CTL_UNF   = 3;
    localparam int CTL_LINK  = 4;
    localparam int CTL_BPEN  = 5;

    localparam logic [6:0] OFF_STATUS  = 7'h00;
    localparam logic [6:0] OFF_CONTROL = 7'h02;
    localparam logic [6:0] OFF_CLEAR   = 7'h04;
    localparam logic [6:0] OFF_PERF    = 7'h06;
    localparam logic [6:0] OFF_SPARE   = 7'h0a;
    localparam logic [6:0] OFF_ID      = 7'h64;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC_HI,
        ST_ACC_LO,
        ST_GATHER,
        ST_DRAIN,
        ST_STEP,
        ST_DONE
    } state_t;
endpackage
`default_nettype wire

// ----- sv/command_fifo_pointer_controller.sv -----
// Command-FIFO pointer controller: register block, gather burst counting
// and consumer drain sequencer. Depends on cfpc_pkg.
// A 32-bit access runs as two 16-bit halves; a control write then drains the
//   consumer burst by burst. A gather drops each whole burst unless linked;
//   a linked burst advances the producer and then drains the consumer.
// Throughput: one item at a time; the drain loop (one burst per cycle
//   through the shared pointer-advance unit) dominates the time an item takes.
// Reset: aresetn, synchronous, active low, zeroes all registers but item data.
`default_nettype none
module command_fifo_pointer_controller
    import cfpc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata: cmd[1:0], reg_offset[8:2], access_size[11:9],
    //        write_data[43:12], gather_bytes[50:44], zero fill to 56
    input  wire logic [55:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: read_data[31:0], ok[32], status_bits[37:33], interrupt[38], zero to 40
    output logic [39:0]      m_tdata
);
    state_t state_reg, state_next;

    // architectural registers
    logic [5:0]  ctl_reg, ctl_next;
    logic [2:0]  perf_reg, perf_next;
    logic [7:0]  spare_reg, spare_next;
    logic [31:0] base_reg, base_next, end_reg, end_next;
    logic [31:0] hwm_reg, hwm_next, lwm_reg, lwm_next;
    logic [31:0] dist_reg, dist_next, prod_reg, prod_next;
    logic [31:0] cons_reg, cons_next, brk_reg, brk_next;
    logic [6:0]  pend_reg, pend_next;

    // item being worked on
    logic [1:0]  cmd_reg, cmd_next;
    logic [6:0]  off_reg, off_next;
    logic        wide_reg, wide_next;
    logic [31:0] wdata_reg, wdata_next;
    logic [7:0]  acc_reg, acc_next;     // gather byte count still to burst
    logic        ok_reg, ok_next;
    logic [31:0] rdata_reg, rdata_next;
    logic        cbefore_chk_reg, cbefore_chk_next; // drain follows a moved burst
    logic [31:0] cbefore_reg, cbefore_next;
    logic [39:0] out_reg, out_next;
    logic        ovalid_reg, ovalid_next;

    // status from current state
    logic bp_hit, over_hi, under_lo, irq;
    logic [4:0] status;
    always_comb begin
        bp_hit   = ctl_reg[CTL_BPEN] && (cons_reg == brk_reg);
        over_hi  = dist_reg > hwm_reg;
        under_lo = dist_reg < lwm_reg;
        status   = {bp_hit,
                    (dist_reg == '0) || !ctl_reg[CTL_READ] || bp_hit,
                    (dist_reg == '0) || (cons_reg == prod_reg),
                    under_lo, over_hi};
        irq = ctl_reg[CTL_READ] && ((bp_hit && ctl_reg[CTL_BPINT]) ||
              (over_hi && ctl_reg[CTL_OVF]) || (under_lo && ctl_reg[CTL_UNF]));
    end

    // shared pointer-advance unit
    logic        adv_prod;
    logic [31:0] adv_in, adv_out;
    logic [32:0] adv_sum;
    always_comb begin
        adv_in  = adv_prod ? prod_reg : cons_reg;
        adv_sum = {1'b0, adv_in} + {1'b0, BURST32};
        if (base_reg == '0 && end_reg == '0)
            adv_out = adv_in;
        else if (adv_in < base_reg || adv_in > end_reg || adv_sum > {1'b0, end_reg})
            adv_out = base_reg;
        else
            adv_out = adv_sum[31:0] & ADDR_MASK;
    end

    // 16-bit register decode at the current half offset
    logic [6:0]  hoff;
    logic [15:0] rd16;
    logic        rd_ok, wr_ok, is_pair;
    logic [31:0] pair_val;
    logic [15:0] wv;
    always_comb begin
        hoff = (wide_reg && state_reg == ST_ACC_LO) ? off_reg + 7'd2 : off_reg;
        wv   = (wide_reg && state_reg == ST_ACC_HI) ? wdata_reg[31:16] : wdata_reg[15:0];
        is_pair = (hoff[6:5] == 2'b01) && !hoff[0];
        case (hoff[4:2])
            3'd0:    pair_val = base_reg;
            3'd1:    pair_val = end_reg;
            3'd2:    pair_val = hwm_reg;
            3'd3:    pair_val = lwm_reg;
            3'd4:    pair_val = dist_reg;
            3'd5:    pair_val = prod_reg;
            3'd6:    pair_val = cons_reg;
            default: pair_val = brk_reg;
        endcase
        rd16  = '0;
        rd_ok = 1'b0;
        wr_ok = 1'b0;
        case (hoff)
            OFF_STATUS:  begin rd16 = {11'd0, status}; rd_ok = 1'b1; end
            OFF_CONTROL: begin rd16 = {10'd0, ctl_reg}; rd_ok = 1'b1; wr_ok = 1'b1; end
            OFF_CLEAR:   begin rd_ok = 1'b1; wr_ok = 1'b1; end
            OFF_PERF:    begin rd16 = {13'd0, perf_reg}; rd_ok = 1'b1; wr_ok = 1'b1; end
            OFF_SPARE:   begin rd16 = {8'd0, spare_reg}; rd_ok = 1'b1; wr_ok = 1'b1; end
            OFF_ID:      begin rd16 = 16'd4; rd_ok = 1'b1; end
            default: begin
                if ((hoff >= 7'h40 && hoff <= 7'h5a) || hoff == 7'h60 || hoff == 7'h62)
                    rd_ok = 1'b1;
                else if (is_pair) begin
                    rd_ok = 1'b1;
                    wr_ok = 1'b1;
                    rd16  = hoff[1] ? pair_val[31:16] : pair_val[15:0];
                end
            end
        endcase
    end

    logic [55:0] in_d;
    logic        size_ok2, size_ok4;
    logic [31:0] dmin, span, dplus;
    always_comb begin
        in_d     = s_tdata;
        size_ok2 = (in_d[11:9] == 3'd2) && !in_d[2];
        size_ok4 = (in_d[11:9] == 3'd4) && (in_d[3:2] == 2'b00);
        span     = (end_reg >= base_reg) ? end_reg - base_reg + BURST32 : '0;
        dplus    = dist_reg + BURST32;
        dmin     = (span != '0 && dplus >= span) ? span : dplus;
    end

    always_comb begin
        state_next = state_reg;
        ctl_next = ctl_reg; perf_next = perf_reg; spare_next = spare_reg;
        base_next = base_reg; end_next = end_reg; hwm_next = hwm_reg; lwm_next = lwm_reg;
        dist_next = dist_reg; prod_next = prod_reg; cons_next = cons_reg;
        brk_next = brk_reg; pend_next = pend_reg;
        cmd_next = cmd_reg; off_next = off_reg; wide_next = wide_reg;
        wdata_next = wdata_reg; acc_next = acc_reg; ok_next = ok_reg;
        rdata_next = rdata_reg; cbefore_next = cbefore_reg;
        cbefore_chk_next = cbefore_chk_reg;
        out_next = out_reg; ovalid_next = ovalid_reg;
        adv_prod = 1'b0;
        s_tready = (state_reg == ST_IDLE);
        if (ovalid_reg && m_tready) ovalid_next = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd_next   = in_d[1:0];
                    off_next   = in_d[8:2];
                    wdata_next = in_d[43:12];
                    wide_next  = !size_ok2;
                    acc_next   = {1'b0, pend_reg} + {1'b0, in_d[50:44]};
                    ok_next    = 1'b0;
                    rdata_next = '0;
                    case (in_d[1:0])
                        CMD_READ, CMD_WRITE:
                            state_next = (size_ok2 || size_ok4) ? ST_ACC_HI : ST_DONE;
                        CMD_GATHER: state_next = ST_GATHER;
                        default:    state_next = ST_STEP;
                    endcase
                end
            end
            ST_ACC_HI, ST_ACC_LO: begin
                if (cmd_reg == CMD_READ) begin
                    rdata_next = {rdata_reg[15:0], rd16};
                    if (!rd_ok) begin
                        rdata_next = '0;
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        ok_next    = 1'b1;
                        state_next = (wide_reg && state_reg == ST_ACC_HI) ? ST_ACC_LO : ST_DONE;
                    end
                end else begin
                    if (!wr_ok) begin
                        ok_next    = 1'b0;
                        state_next = ST_DONE;
                    end else begin
                        ok_next    = 1'b1;
                        state_next = (wide_reg && state_reg == ST_ACC_HI) ? ST_ACC_LO : ST_DONE;
                        case (hoff)
                            OFF_CONTROL: begin
                                ctl_next = wv[5:0];
                                cbefore_chk_next = 1'b0;
                                state_next = ST_DRAIN;
                            end
                            OFF_CLEAR: ;
                            OFF_PERF:  perf_next = wv[2:0];
                            OFF_SPARE: spare_next = wv[7:0];
                            default: begin
                                logic [31:0] nv;
                                nv = hoff[1] ? {wv, pair_val[15:0]} : {pair_val[31:16], wv};
                                nv = nv & ADDR_MASK;
                                case (hoff[4:2])
                                    3'd0:    base_next = nv;
                                    3'd1:    end_next = nv;
                                    3'd2:    hwm_next = nv;
                                    3'd3:    lwm_next = nv;
                                    3'd4:    dist_next = nv;
                                    3'd5:    prod_next = nv;
                                    3'd6:    cons_next = nv;
                                    default: brk_next = nv;
                                endcase
                            end
                        endcase
                    end
                end
            end
            ST_GATHER: begin
                if (acc_reg >= 8'd32) begin
                    acc_next = acc_reg - 8'd32;
                    if (ctl_reg[CTL_LINK]) begin
                        ok_next   = 1'b1;
                        adv_prod  = 1'b1;
                        prod_next = adv_out;
                        dist_next = dmin;
                        cbefore_chk_next = 1'b0;
                        state_next = ST_DRAIN;
                    end
                end else begin
                    pend_next  = acc_reg[6:0];
                    state_next = ST_DONE;
                end
            end
            ST_DRAIN: begin
                // one loop pass: post-checks of the previous burst, then the next
                if (cbefore_chk_reg && (bp_hit || cons_reg == prod_reg || cons_reg == cbefore_reg)) begin
                    if (!bp_hit && cons_reg == prod_reg) dist_next = '0;
                    state_next = (cmd_reg == CMD_GATHER) ? ST_GATHER
                               : (wide_reg && off_reg == OFF_CONTROL) ? ST_ACC_LO : ST_DONE;
                end else if (!ctl_reg[CTL_READ] || dist_reg == '0 || bp_hit ||
                             dist_reg < BURST32) begin
                    state_next = (cmd_reg == CMD_GATHER) ? ST_GATHER
                               : (wide_reg && off_reg == OFF_CONTROL) ? ST_ACC_LO : ST_DONE;
                end else begin
                    cbefore_next = cons_reg;
                    cons_next    = adv_out;
                    dist_next    = dist_reg - BURST32;
                    cbefore_chk_next = 1'b1;
                end
            end
            ST_STEP: begin
                if (ctl_reg[CTL_READ] && bp_hit && !ctl_reg[CTL_BPINT] && dist_reg >= BURST32) begin
                    cons_next = adv_out;
                    dist_next = (adv_out == prod_reg) ? '0 : dist_reg - BURST32;
                    ok_next   = adv_out != cons_reg;
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!ovalid_reg || m_tready) begin
                    out_next    = {1'b0, irq, status, ok_reg, rdata_reg};
                    ovalid_next = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = ovalid_reg;
    assign m_tdata  = out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ovalid_reg <= 1'b0;
            ctl_reg <= '0; perf_reg <= '0; spare_reg <= '0;
            base_reg <= '0; end_reg <= '0; hwm_reg <= '0; lwm_reg <= '0;
            dist_reg <= '0; prod_reg <= '0; cons_reg <= '0; brk_reg <= '0;
            pend_reg <= '0;
            cbefore_chk_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
            ctl_reg <= ctl_next; perf_reg <= perf_next; spare_reg <= spare_next;
            base_reg <= base_next; end_reg <= end_next; hwm_reg <= hwm_next;
            lwm_reg <= lwm_next; dist_reg <= dist_next; prod_reg <= prod_next;
            cons_reg <= cons_next; brk_reg <= brk_next; pend_reg <= pend_next;
            cbefore_chk_reg <= cbefore_chk_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next; off_reg <= off_next; wide_reg <= wide_next;
        wdata_reg <= wdata_next; acc_reg <= acc_next; ok_reg <= ok_next;
        rdata_reg <= rdata_next; cbefore_reg <= cbefore_next; out_reg <= out_next;
    end
endmodule
`default_nettype wire

// ----- sv/cfpc_checker.sv -----
// Port-level checker for command_fifo_pointer_controller, bound to the top.
// Depends only on command_fifo_pointer_controller, which it binds into.
`default_nettype none
module cfpc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("second item taken while busy");
    a_pad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !m_tdata[39]) else $error("pad bit set");
    a_rd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[32] |-> m_tdata[31:0] == 32'd0) else $error("data on failed item");
endmodule

bind command_fifo_pointer_controller cfpc_checker u_cfpc_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
